// ----- rtl/sdq_pkg.sv -----
// Shared types and constants for the sorted double-ended queue.
`default_nettype none
package sdq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 2'd0,
    MODE_POP_MIN = 2'd1,
    MODE_POP_MAX = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_e;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_e op;
    data_t    ins_value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/sdq_cell.sv -----
// One slot of the sorted chain: holds a word and trades it with its neighbors.
`default_nettype none
module sdq_cell
  import sdq_pkg::*;
(
  input  wire             clk_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire             occ_i,       // slot lies below the current count
  input  wire             left_lt_i,   // left neighbor keeps its word on insert
  input  wire data_t      left_val_i,
  input  wire data_t      right_val_i,
  output logic            lt_o,
  output data_t           val_o
);

  data_t val_q;
  data_t val_d;

  // Stored word sorts strictly below the incoming one.
  assign lt_o  = occ_i && (val_q < ctrl_i.ins_value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        // keep below the insert point, take the new word at it, shift up above it
        if (lt_o) begin
          val_d = val_q;
        end else if (left_lt_i) begin
          val_d = ctrl_i.ins_value;
        end else begin
          val_d = left_val_i;
        end
      end
      CELL_SHIFT: val_d = right_val_i;
      default:    val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule
`default_nettype wire

// ----- rtl/sorted_double_ended_queue_core.sv -----
// Top level of the sorted double-ended queue: cell chain, count and result register.
// Keeps up to 16 signed 32-bit words in ascending order in a row of cells. Every
// command (insert, remove smallest, remove largest) is accepted at once: busy never
// rises, so a command may be issued on every clock. The cells all update at the
// edge that accepts the command, each comparing its word with the new one and
// taking its own, its left or its right neighbor's word. The result appears on
// the result ports in the cycle after acceptance, marked by done_o for exactly one
// cycle; it must be taken then, since nothing holds it.
`default_nettype none
module sorted_double_ended_queue_core
  import sdq_pkg::*;
(
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire  [MODE_W-1:0]           mode_i,
  input  wire  signed [DATA_WIDTH-1:0] value_i,
  output logic                        done_o,
  output logic signed [DATA_WIDTH-1:0] result_value_o,
  output logic [STATUS_W-1:0]         status_o,
  output logic [OCC_W-1:0]            occupancy_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q, done_d;
  data_t            res_q, res_d;
  status_e          status_q, status_d;

  cell_ctrl_t ctrl;
  data_t      vals [CAPACITY];
  logic       lts  [CAPACITY];
  logic       accept;
  logic       full, empty;
  logic [IDX_W-1:0] top_idx;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);
  assign top_idx = IDX_W'(count_q - CNT_W'(1));

  always_comb begin
    count_d        = count_q;
    res_d          = '0;
    status_d       = ST_OK;
    done_d         = accept;
    ctrl.op        = CELL_HOLD;
    ctrl.ins_value = value_i;
    if (accept) begin
      case (mode_e'(mode_i))
        MODE_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.op = CELL_INSERT;
            count_d = count_q + CNT_W'(1);
            res_d   = value_i;
          end
        end
        MODE_POP_MIN: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.op = CELL_SHIFT;
            count_d = count_q - CNT_W'(1);
            res_d   = vals[0];
          end
        end
        MODE_POP_MAX: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            count_d = count_q - CNT_W'(1);
            res_d   = vals[top_idx];
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  left_lt;
    data_t left_val;
    data_t right_val;
    logic  occ;

    assign occ = (CNT_W'(i) < count_q);
    if (i == 0) begin : g_first
      // slot zero is always at or above the insert point
      assign left_lt  = 1'b1;
      assign left_val = value_i;
    end else begin : g_mid
      assign left_lt  = lts[i-1];
      assign left_val = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    sdq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .left_lt_i   (left_lt),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .lt_o        (lts[i]),
      .val_o       (vals[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;
  assign occupancy_o    = OCC_W'(count_q);

endmodule
`default_nettype wire

// ----- rtl/sdq_checker.sv -----
// Port-level checks for the sorted double-ended queue, bound to the top level.
`default_nettype none
module sdq_checker
  import sdq_pkg::*;
(
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          start,
  input wire                          busy,
  input wire  [MODE_W-1:0]            mode_i,
  input wire  signed [DATA_WIDTH-1:0] value_i,
  input wire                          done_o,
  input wire  signed [DATA_WIDTH-1:0] result_value_o,
  input wire  [STATUS_W-1:0]          status_o,
  input wire  [OCC_W-1:0]             occupancy_o
);

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted command gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result word without a command");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (result_value_o == '0 && occupancy_o == '0))
    else $error("empty removal must return zero on an empty queue");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (occupancy_o == OCC_W'(CAPACITY)))
    else $error("full status with room left");

  a_insert_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i == MODE_INSERT) |=>
      (status_o == ST_FULL || result_value_o == $past(value_i)))
    else $error("insert did not return its word");

endmodule

bind sorted_double_ended_queue_core sdq_checker u_sdq_checker (.*);
`default_nettype wire

// ----- tb/sv/sorted_double_ended_queue_core_tb.sv -----
// Self-checking testbench for the sorted double-ended queue core.
module sorted_double_ended_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdq_pkg::*;

  typedef struct {
    mode_e mode;
    data_t value;
    int    idle_pct;
    bit    wait_drain;
  } command_t;

  typedef struct {
    data_t                value;
    status_e              status;
    logic [OCC_W-1:0]     occupancy;
  } queue_result_t;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 start   = 1'b0;
  logic [MODE_W-1:0]    mode_i  = MODE_INSERT;
  data_t                value_i = '0;
  logic                 busy;
  logic                 done_o;
  data_t                result_value_o;
  logic [STATUS_W-1:0]  status_o;
  logic [OCC_W-1:0]     occupancy_o;

  command_t       command_q[$];
  queue_result_t  pending_results[$];
  data_t          held_words[$];
  int unsigned    fail_count = 0;

  sorted_double_ended_queue_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Update the sorted shadow store and queue the word the block must return.
  function automatic void apply_command(logic [MODE_W-1:0] op, data_t v);
    queue_result_t r;
    int pos;
    r.value  = '0;
    r.status = ST_OK;
    case (mode_e'(op))
      MODE_INSERT: begin
        if (held_words.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_words.size() && held_words[pos] < v) pos++;
          held_words.insert(pos, v);
          r.value = v;
        end
      end
      MODE_POP_MIN: begin
        if (held_words.size() == 0) r.status = ST_EMPTY;
        else r.value = held_words.pop_front();
      end
      MODE_POP_MAX: begin
        if (held_words.size() == 0) r.status = ST_EMPTY;
        else r.value = held_words.pop_back();
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(held_words.size());
    pending_results.push_back(r);
  endfunction

  function automatic void add_command(mode_e m, data_t v, int idle, bit drain);
    command_t c;
    c.mode       = m;
    c.value      = v;
    c.idle_pct   = idle;
    c.wait_drain = drain;
    command_q.push_back(c);
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0:       return data_t'(32'h8000_0000);
      1:       return data_t'(32'h7fff_ffff);
      2, 3:    return data_t'(int'($urandom_range(0, 15)) - 8);
      default: return data_t'($urandom);
    endcase
  endfunction

  // Driver: hold a command until accepted, then load the next one or idle.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    command_t nxt;
    if (!rst_ni) begin
      start   <= 1'b0;
      mode_i  <= MODE_INSERT;
      value_i <= '0;
    end else begin
      if (start && !busy) apply_command(mode_i, value_i);
      if (!start || !busy) begin
        if (command_q.size() != 0 &&
            !(command_q[0].wait_drain && pending_results.size() != 0) &&
            $urandom_range(0, 99) >= command_q[0].idle_pct) begin
          nxt = command_q.pop_front();
          start   <= 1'b1;
          mode_i  <= nxt.mode;
          value_i <= nxt.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed word must match the oldest expected one.
  always @(posedge clk_i) begin : check_proc
    queue_result_t exp_r;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected word: result_value %0d status %0d occupancy %0d",
               result_value_o, status_o, occupancy_o);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_value_o !== exp_r.value) begin
          $error("result_value: expected %0d, actual %0d", exp_r.value, result_value_o);
          fail_count++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, status_o);
          fail_count++;
        end
        if (occupancy_o !== exp_r.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", exp_r.occupancy, occupancy_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : run_proc
    int idle;
    int bias;
    int r;
    mode_e m;

    // Directed: removals and the unused mode on an empty store.
    add_command(MODE_POP_MIN, data_t'($urandom), 0, 1'b0);
    add_command(MODE_POP_MAX, data_t'($urandom), 0, 1'b0);
    add_command(MODE_NONE, data_t'($urandom), 0, 1'b0);
    // Extremes, duplicates and alternating bit patterns.
    add_command(MODE_INSERT, data_t'(32'h8000_0000), 0, 1'b0);
    add_command(MODE_INSERT, data_t'(32'h7fff_ffff), 0, 1'b0);
    add_command(MODE_INSERT, data_t'(0), 0, 1'b0);
    add_command(MODE_INSERT, data_t'(-1), 0, 1'b0);
    add_command(MODE_INSERT, data_t'(1), 0, 1'b0);
    add_command(MODE_INSERT, data_t'(0), 0, 1'b0);
    add_command(MODE_INSERT, data_t'(32'h5555_5555), 0, 1'b0);
    add_command(MODE_INSERT, data_t'(32'haaaa_aaaa), 0, 1'b0);
    // Fill to capacity, then insert into a full store after a drain.
    for (int i = 0; i < CAPACITY - 8; i++)
      add_command(MODE_INSERT, pick_value(), 0, 1'b0);
    add_command(MODE_INSERT, data_t'($urandom), 0, 1'b1);
    add_command(MODE_NONE, data_t'($urandom), 0, 1'b0);
    add_command(MODE_POP_MAX, data_t'($urandom), 0, 1'b0);
    add_command(MODE_POP_MIN, data_t'($urandom), 0, 1'b0);

    // Random: blocks that lean toward filling or draining the store.
    bias = 50;
    for (int i = 0; i < 1000; i++) begin
      if (i % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       bias = 85;
          1:       bias = 50;
          default: bias = 20;
        endcase
      end
      if (i < 333) idle = 29;
      else if (i < 666) idle = 61;
      else idle = 0;
      r = $urandom_range(0, 99);
      if (r < 4) m = MODE_NONE;
      else if (r < bias) m = MODE_INSERT;
      else if ($urandom_range(0, 1) == 0) m = MODE_POP_MIN;
      else m = MODE_POP_MAX;
      add_command(m, pick_value(), idle, (i % 250 == 0));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (command_q.size() != 0 || start) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : timeout_proc
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sdq_pkg.sv
rtl/sdq_cell.sv
rtl/sorted_double_ended_queue_core.sv
rtl/sdq_checker.sv
tb/sv/sorted_double_ended_queue_core_tb.sv
